// ----- src/arg_pkg.sv -----
// Shared types and constants for the announcement relay gate.
// Holds mode and stop-cause codes, register indexes and the item, state, config and result structs.
// No dependencies.
package arg_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 1279;

    localparam int TIME_W = 48;
    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 11;
    localparam int ADDR_W = 32;
    localparam int CONN_W = 8;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [LEN_W-1:0] HDR_BYTES = 11'd4;
    localparam logic [7:0]       LOST_MAX  = 8'd255;

    localparam logic [CFG_W-1:0] MAX_DURATION_RST = 32'd180000000;
    localparam logic [CFG_W-1:0] SILENCE_RST      = 32'd1000000;
    localparam logic [CFG_W-1:0] GRACE_RST        = 32'd3000000;
    localparam logic [CFG_W-1:0] REFRESH_RST      = 32'd1000000;
    localparam logic [CFG_W-1:0] PRIMER_RST       = 32'd10000;

    localparam logic [IDX_W-1:0] REG_MAX_DURATION = 3'd0;
    localparam logic [IDX_W-1:0] REG_SILENCE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_GRACE        = 3'd2;
    localparam logic [IDX_W-1:0] REG_REFRESH      = 3'd3;
    localparam logic [IDX_W-1:0] REG_PRIMER       = 3'd4;

    typedef enum logic [2:0] {
        MODE_PACKET = 3'd0,
        MODE_TICK   = 3'd1,
        MODE_START  = 3'd2,
        MODE_STOP   = 3'd3,
        MODE_CLOSE  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_DURATION = 3'd1,
        CAUSE_SILENCE  = 3'd2,
        CAUSE_NO_AUDIO = 3'd3,
        CAUSE_STOP     = 3'd4,
        CAUSE_CLOSED   = 3'd5
    } cause_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_duration_us;
        logic [CFG_W-1:0] silence_limit_us;
        logic [CFG_W-1:0] start_grace_us;
        logic [CFG_W-1:0] refresh_period_us;
        logic [CFG_W-1:0] primer_period_us;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [TIME_W-1:0] now_us;
        logic [LEN_W-1:0]  packet_length;
        logic [ADDR_W-1:0] sender_address;
        logic [SEQ_W-1:0]  sequence_number;
        logic [CONN_W-1:0] connection_id;
    } item_t;

    typedef struct packed {
        logic              session_on;
        logic [CONN_W-1:0] owner_connection;
        logic [ADDR_W-1:0] owner_address;
        logic [TIME_W-1:0] start_time;
        logic              audio_seen;
        logic              phone_seq_valid;
        logic [SEQ_W-1:0]  last_phone_seq;
        logic [SEQ_W-1:0]  out_seq_counter;
        logic [TIME_W-1:0] last_audio_time;
        logic [TIME_W-1:0] last_primer_time;
        logic [TIME_W-1:0] last_refresh_time;
    } state_t;

    typedef struct packed {
        logic             relay_audio;
        logic             send_primer;
        logic [SEQ_W-1:0] stamped_sequence;
        logic [7:0]       lost_count;
        logic [LEN_W-1:0] payload_length;
        logic             announce_on;
        logic [2:0]       stop_cause;
        logic             new_session;
        logic             end_of_session;
        logic             start_ok;
        logic             refresh_targets;
    } result_t;

endpackage

// ----- src/arg_step.sv -----
// Single-step session logic of the announcement relay gate.
// Maps one item, the current state and the registers to a result and the next state.
// Depends on arg_pkg.
module arg_step
    import arg_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output result_t result,
    output state_t  state_next
);

    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] ref_time);
        return (now >= ref_time) ? (now - ref_time) : '0;
    endfunction

    logic              do_start;
    logic              run;
    logic              got;
    logic [SEQ_W-1:0]  seq_diff;
    logic [SEQ_W-1:0]  seq_gap;
    logic [7:0]        lost;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] refresh_eff;
    logic              audio_eff;
    logic              seq_valid_eff;
    logic              audio_after;
    logic [TIME_W-1:0] audio_time_after;
    logic [TIME_W-1:0] since_start;
    logic              wd_duration;
    logic              wd_silence;
    logic              wd_grace;
    logic              wd_end;
    logic              len_ok;
    logic              sender_ok;
    logic              seq_ok;
    logic              primer_due;
    logic              end_cmd;
    logic [2:0]        end_cause;

    always_comb begin
        do_start = (item.mode == MODE_START) && !state.session_on;
        run      = do_start || (state.session_on &&
                   (item.mode == MODE_PACKET || item.mode == MODE_TICK));

        // a fresh session sees its own start values in the same step
        start_eff     = do_start ? item.now_us : state.start_time;
        refresh_eff   = do_start ? item.now_us : state.last_refresh_time;
        audio_eff     = do_start ? 1'b0 : state.audio_seen;
        seq_valid_eff = do_start ? 1'b0 : state.phone_seq_valid;

        len_ok    = (item.packet_length > HDR_BYTES) &&
                    (item.packet_length <= LEN_W'(MAX_PACKET_BYTES));
        sender_ok = (state.owner_address == '0) ||
                    (item.sender_address == state.owner_address);
        seq_diff  = item.sequence_number - state.last_phone_seq;
        seq_gap   = seq_diff - 32'd1;
        seq_ok    = !seq_valid_eff || ((seq_diff != '0) && !seq_diff[SEQ_W-1]);
        got       = run && !do_start && (item.mode == MODE_PACKET) &&
                    len_ok && sender_ok && seq_ok;

        if (seq_valid_eff && seq_diff > 32'd1) begin
            lost = (seq_gap > 32'(LOST_MAX)) ? LOST_MAX : seq_gap[7:0];
        end else begin
            lost = '0;
        end

        audio_after      = audio_eff || got;
        audio_time_after = got ? item.now_us : state.last_audio_time;
        since_start      = elapsed(item.now_us, start_eff);

        wd_duration = since_start > TIME_W'(cfg.max_duration_us);
        wd_silence  = audio_after &&
                      (elapsed(item.now_us, audio_time_after) > TIME_W'(cfg.silence_limit_us));
        wd_grace    = !audio_after && (since_start > TIME_W'(cfg.start_grace_us));
        wd_end      = run && (wd_duration || wd_silence || wd_grace);

        primer_due = !audio_after &&
                     (elapsed(item.now_us, state.last_primer_time) >=
                      TIME_W'(cfg.primer_period_us));

        end_cmd = state.session_on &&
                  ((item.mode == MODE_STOP) ||
                   (item.mode == MODE_CLOSE && state.owner_connection == item.connection_id));
        end_cause = (item.mode == MODE_STOP) ? CAUSE_STOP : CAUSE_CLOSED;

        state_next = state;
        result     = '0;

        if (do_start) begin
            state_next.session_on        = 1'b1;
            state_next.owner_connection  = item.connection_id;
            state_next.owner_address     = item.sender_address;
            state_next.start_time        = item.now_us;
            state_next.audio_seen        = 1'b0;
            state_next.phone_seq_valid   = 1'b0;
            state_next.last_refresh_time = item.now_us;
            result.new_session           = 1'b1;
            result.start_ok              = 1'b1;
            result.refresh_targets       = 1'b1;
        end

        if (got) begin
            state_next.last_phone_seq  = item.sequence_number;
            state_next.phone_seq_valid = 1'b1;
            state_next.audio_seen      = 1'b1;
            state_next.last_audio_time = item.now_us;
        end

        if (wd_end || end_cmd) begin
            state_next.session_on        = 1'b0;
            state_next.owner_connection  = '0;
            state_next.last_refresh_time = item.now_us;
            result.end_of_session        = 1'b1;
            result.refresh_targets       = 1'b1;
            if (end_cmd) begin
                result.stop_cause = end_cause;
            end else if (wd_duration) begin
                result.stop_cause = CAUSE_DURATION;
            end else if (wd_silence) begin
                result.stop_cause = CAUSE_SILENCE;
            end else begin
                result.stop_cause = CAUSE_NO_AUDIO;
            end
        end else if (run) begin
            if (elapsed(item.now_us, refresh_eff) > TIME_W'(cfg.refresh_period_us)) begin
                state_next.last_refresh_time = item.now_us;
                result.refresh_targets       = 1'b1;
            end
            if (got) begin
                result.relay_audio         = 1'b1;
                result.stamped_sequence    = state.out_seq_counter;
                result.lost_count          = lost;
                result.payload_length      = item.packet_length - HDR_BYTES;
                state_next.out_seq_counter = state.out_seq_counter + 32'd1;
            end else if (primer_due) begin
                result.send_primer          = 1'b1;
                result.stamped_sequence     = state.out_seq_counter;
                state_next.out_seq_counter  = state.out_seq_counter + 32'd1;
                state_next.last_primer_time = item.now_us;
            end
        end

        result.announce_on = state_next.session_on;
    end

endmodule

// ----- src/announce_relay_gate.sv -----
// Announcement relay gate: one result beat for every input beat.
// Each input beat passes through the input register and then the result register.
// One beat per cycle unless m_tready stalls; state updates in the same cycle as the result.
// Reset (aresetn low, synchronous) clears the session state and loads the register defaults.
// Depends on arg_pkg and arg_step.
module announce_relay_gate
    import arg_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [47:0] now_us, [58:48] packet_length, [90:59] sender_address,
    // [122:91] sequence_number, [130:123] connection_id
    input  logic [135:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] relay_audio, [1] send_primer, [33:2] stamped_sequence, [41:34] lost_count,
    // [52:42] payload_length, [53] announce_on, [56:54] stop_cause, [57] new_session,
    // [58] end_of_session, [59] start_ok, [60] refresh_targets
    output logic [63:0]  m_tdata,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    state_t  state_reg;
    state_t  state_next;
    cfg_t    cfg_reg;
    result_t result_next;
    logic    advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    arg_step #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_step (
        .item      (in_item_reg),
        .state     (state_reg),
        .cfg       (cfg_reg),
        .result    (result_next),
        .state_next(state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.mode            <= s_tuser;
            in_item_reg.now_us          <= s_tdata[47:0];
            in_item_reg.packet_length   <= s_tdata[58:48];
            in_item_reg.sender_address  <= s_tdata[90:59];
            in_item_reg.sequence_number <= s_tdata[122:91];
            in_item_reg.connection_id   <= s_tdata[130:123];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_duration_us   <= MAX_DURATION_RST;
            cfg_reg.silence_limit_us  <= SILENCE_RST;
            cfg_reg.start_grace_us    <= GRACE_RST;
            cfg_reg.refresh_period_us <= REFRESH_RST;
            cfg_reg.primer_period_us  <= PRIMER_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_DURATION: cfg_reg.max_duration_us   <= cfg_data;
                REG_SILENCE:      cfg_reg.silence_limit_us  <= cfg_data;
                REG_GRACE:        cfg_reg.start_grace_us    <= cfg_data;
                REG_REFRESH:      cfg_reg.refresh_period_us <= cfg_data;
                REG_PRIMER:       cfg_reg.primer_period_us  <= cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.refresh_targets,
                       out_result_reg.start_ok,
                       out_result_reg.end_of_session,
                       out_result_reg.new_session,
                       out_result_reg.stop_cause,
                       out_result_reg.announce_on,
                       out_result_reg.payload_length,
                       out_result_reg.lost_count,
                       out_result_reg.stamped_sequence,
                       out_result_reg.send_primer,
                       out_result_reg.relay_audio};

endmodule

// ----- sim/announce_relay_gate_tb.sv -----
// Self-checking testbench for announce_relay_gate: directed and random beats
// checked against an in-bench session predictor. Depends on arg_pkg and the RTL.
`timescale 1ns / 100ps

module announce_relay_gate_tb;
    import arg_pkg::*;

    localparam int          PKT_MAX     = MAX_PACKET_BYTES_DEF;
    localparam logic [31:0] SEQ_HALF    = 32'h8000_0000;
    localparam logic [31:0] REG_TOP     = 32'hFFFF_FFFF;
    localparam int          ITEM_GOAL   = 1650;
    localparam int          PHASES      = 8;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SHOW_MAX    = 100;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    announce_relay_gate #(.MAX_PACKET_BYTES(PKT_MAX)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predicted session state and register file
    state_t      gate;
    cfg_t        regs;
    result_t     pending_results[$];
    logic [47:0] clock_us;

    int cycle_count   = 0;
    int errors        = 0;
    int beats_checked = 0;
    int active_beats  = 0;
    int cfg_writes    = 0;
    int sessions      = 0;
    int relays        = 0;
    int primers       = 0;
    int forced_ends   = 0;
    int no_idle       = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("announce_relay_gate_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [47:0] since_us(input logic [47:0] now, input logic [47:0] mark);
        return (now >= mark) ? now - mark : 48'd0;
    endfunction

    function automatic void close_session(input logic [47:0] now, input cause_t cause,
                                          inout result_t r);
        gate.session_on        = 1'b0;
        gate.owner_connection  = '0;
        gate.last_refresh_time = now;
        r.stop_cause           = cause;
        r.end_of_session       = 1'b1;
        r.refresh_targets      = 1'b1;
    endfunction

    // One round of an active session: accept, watchdogs, refresh, then relay or primer.
    function automatic void session_round(input logic [47:0] now, input logic has_pkt,
                                          input logic [10:0] len, input logic [31:0] addr,
                                          input logic [31:0] seq, inout result_t r);
        logic        got;
        logic [31:0] d;
        logic [31:0] lost;
        got  = 1'b0;
        lost = '0;
        if (has_pkt && len > HDR_BYTES && len <= PKT_MAX &&
            (gate.owner_address == '0 || addr == gate.owner_address)) begin
            d = seq - gate.last_phone_seq;
            if (!gate.phone_seq_valid || (d != '0 && d < SEQ_HALF)) begin
                lost = (gate.phone_seq_valid && d > 32'd1) ? d - 32'd1 : 32'd0;
                if (lost > LOST_MAX)
                    lost = 32'(LOST_MAX);
                gate.last_phone_seq  = seq;
                gate.phone_seq_valid = 1'b1;
                gate.audio_seen      = 1'b1;
                gate.last_audio_time = now;
                got = 1'b1;
            end
        end

        if (since_us(now, gate.start_time) > regs.max_duration_us) begin
            close_session(now, CAUSE_DURATION, r);
            return;
        end
        if (gate.audio_seen && since_us(now, gate.last_audio_time) > regs.silence_limit_us) begin
            close_session(now, CAUSE_SILENCE, r);
            return;
        end
        if (!gate.audio_seen && since_us(now, gate.start_time) > regs.start_grace_us) begin
            close_session(now, CAUSE_NO_AUDIO, r);
            return;
        end

        if (since_us(now, gate.last_refresh_time) > regs.refresh_period_us) begin
            gate.last_refresh_time = now;
            r.refresh_targets      = 1'b1;
        end

        if (got) begin
            r.relay_audio      = 1'b1;
            r.stamped_sequence = gate.out_seq_counter;
            r.lost_count       = lost[7:0];
            r.payload_length   = len - HDR_BYTES;
            gate.out_seq_counter++;
        end else if (!gate.audio_seen &&
                     since_us(now, gate.last_primer_time) >= regs.primer_period_us) begin
            r.send_primer         = 1'b1;
            r.stamped_sequence    = gate.out_seq_counter;
            gate.out_seq_counter++;
            gate.last_primer_time = now;
        end
    endfunction

    function automatic result_t gate_step(input item_t it);
        result_t r;
        r = '0;
        case (it.mode)
            MODE_PACKET, MODE_TICK: begin
                if (gate.session_on)
                    session_round(it.now_us, it.mode == MODE_PACKET, it.packet_length,
                                  it.sender_address, it.sequence_number, r);
            end
            MODE_START: begin
                if (!gate.session_on) begin
                    gate.session_on        = 1'b1;
                    gate.owner_connection  = it.connection_id;
                    gate.owner_address     = it.sender_address;
                    gate.start_time        = it.now_us;
                    gate.audio_seen        = 1'b0;
                    gate.phone_seq_valid   = 1'b0;
                    gate.last_refresh_time = it.now_us;
                    r.new_session          = 1'b1;
                    r.start_ok             = 1'b1;
                    r.refresh_targets      = 1'b1;
                    session_round(it.now_us, 1'b0, '0, '0, '0, r);
                end
            end
            MODE_STOP: begin
                if (gate.session_on)
                    close_session(it.now_us, CAUSE_STOP, r);
            end
            MODE_CLOSE: begin
                if (gate.session_on && gate.owner_connection == it.connection_id)
                    close_session(it.now_us, CAUSE_CLOSED, r);
            end
            default: ;
        endcase
        r.announce_on = gate.session_on;
        return r;
    endfunction

    // Send one beat; valid stays high when the next beat follows without a gap.
    task automatic send_beat(input item_t it);
        int      gap;
        result_t r;
        gap = (no_idle != 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {5'd0, it.connection_id, it.sequence_number, it.sender_address,
                     it.packet_length, it.now_us};
        do @(posedge aclk); while (!s_tready);
        r = gate_step(it);
        pending_results.push_back(r);
        if (r.announce_on || r.end_of_session)
            active_beats++;
        if (r.new_session)
            sessions++;
        if (r.relay_audio)
            relays++;
        if (r.send_primer)
            primers++;
        if (r.stop_cause inside {CAUSE_DURATION, CAUSE_SILENCE, CAUSE_NO_AUDIO})
            forced_ends++;
    endtask

    task automatic send_fields(input logic [2:0] mode, input logic [47:0] now,
                               input logic [10:0] len, input logic [31:0] addr,
                               input logic [31:0] seq, input logic [7:0] conn);
        item_t it;
        it.mode            = mode;
        it.now_us          = now;
        it.packet_length   = len;
        it.sender_address  = addr;
        it.sequence_number = seq;
        it.connection_id   = conn;
        send_beat(it);
    endtask

    // Hold the sender until every result is back, then let the pipeline empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_DURATION: regs.max_duration_us   = value;
            REG_SILENCE:      regs.silence_limit_us  = value;
            REG_GRACE:        regs.start_grace_us    = value;
            REG_REFRESH:      regs.refresh_period_us = value;
            REG_PRIMER:       regs.primer_period_us  = value;
            default: ;
        endcase
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] dur, input logic [31:0] sil,
                                 input logic [31:0] grace, input logic [31:0] refresh,
                                 input logic [31:0] primer);
        drain_results();
        cfg_write(REG_MAX_DURATION, dur);
        cfg_write(REG_SILENCE, sil);
        cfg_write(REG_GRACE, grace);
        cfg_write(REG_REFRESH, refresh);
        cfg_write(REG_PRIMER, primer);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            errors++;
            if (errors <= SHOW_MAX)
                $display("%0t: %s expected %0h actual %0h", $time, fname, want, seen);
            if (errors == SHOW_MAX)
                $display("%0t: further mismatches counted but not shown", $time);
        end
    endtask

    // Result side: random stalls, then compare each beat with the oldest prediction.
    initial begin : result_side
        int      stall;
        result_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = (no_idle != 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            beats_checked++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, actual %0h", $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("relay_audio", 32'(want.relay_audio), 32'(m_tdata[0]));
                check_field("send_primer", 32'(want.send_primer), 32'(m_tdata[1]));
                check_field("stamped_sequence", want.stamped_sequence, m_tdata[33:2]);
                check_field("lost_count", 32'(want.lost_count), 32'(m_tdata[41:34]));
                check_field("payload_length", 32'(want.payload_length),
                            32'(m_tdata[52:42]));
                check_field("announce_on", 32'(want.announce_on), 32'(m_tdata[53]));
                check_field("stop_cause", 32'(want.stop_cause), 32'(m_tdata[56:54]));
                check_field("new_session", 32'(want.new_session), 32'(m_tdata[57]));
                check_field("end_of_session", 32'(want.end_of_session), 32'(m_tdata[58]));
                check_field("start_ok", 32'(want.start_ok), 32'(m_tdata[59]));
                check_field("refresh_targets", 32'(want.refresh_targets),
                            32'(m_tdata[60]));
            end
        end
    end

    // Reset-default registers: idle no-ops, owner checks, length and sequence edges.
    task automatic test_directed_defaults();
        logic [31:0] owner;
        int          k;
        owner = 32'hC0A8_0105;
        send_fields(MODE_TICK,   48'd20000, 11'd0, '0, '0, 8'd0);
        send_fields(MODE_PACKET, 48'd20000, 11'd100, owner, 32'd1, 8'd0);
        send_fields(MODE_STOP,   48'd20000, 11'd0, '0, '0, 8'd0);
        send_fields(MODE_CLOSE,  48'd20000, 11'd0, '0, '0, 8'd3);
        for (k = 1; k <= 3; k++)
            send_fields(3'(MODE_CLOSE + k), 48'd20000, 11'h7FF, REG_TOP, REG_TOP, 8'hFF);
        // start triggers an immediate primer; a second start is refused
        send_fields(MODE_START,  48'd20000, 11'd0, owner, '0, 8'd7);
        send_fields(MODE_START,  48'd20010, 11'd0, 32'h0A00_0001, '0, 8'd9);
        send_fields(MODE_PACKET, 48'd20020, 11'd4, owner, 32'd5, 8'd0);
        send_fields(MODE_PACKET, 48'd20030, 11'(PKT_MAX + 1), owner, 32'd5, 8'd0);
        send_fields(MODE_PACKET, 48'd20040, 11'd100, 32'h0A00_0001, 32'd5, 8'd0);
        // sequence wraps through zero, then a gap that saturates the lost count
        send_fields(MODE_PACKET, 48'd20050, 11'd5, owner, 32'hFFFF_FFFE, 8'd0);
        send_fields(MODE_PACKET, 48'd20060, 11'(PKT_MAX), owner, 32'hFFFF_FFFF, 8'd0);
        send_fields(MODE_PACKET, 48'd20070, 11'd60, owner, 32'hFFFF_FFFF, 8'd0);
        send_fields(MODE_PACKET, 48'd600000, 11'd60, owner, 32'h0000_0200, 8'd0);
        send_fields(MODE_PACKET, 48'd600010, 11'd60, owner, 32'h0000_0100, 8'd0);
        send_fields(MODE_PACKET, 48'd600020, 11'h7FF, owner, 32'h0000_0201, 8'd0);
        send_fields(MODE_TICK,   48'd1100000, 11'd0, '0, '0, 8'd0);
        // time running backwards reads as no elapsed time
        send_fields(MODE_TICK,   48'd500000, 11'd0, '0, '0, 8'd0);
        send_fields(MODE_CLOSE,  48'd1100010, 11'd0, '0, '0, 8'd8);
        send_fields(MODE_CLOSE,  48'd1100020, 11'd0, '0, '0, 8'd7);
        // unknown owner accepts any sender
        send_fields(MODE_START,  48'h0001_0000_0000, 11'd0, '0, '0, 8'hFF);
        send_fields(MODE_PACKET, 48'h0001_0000_0010, 11'd200, REG_TOP, '0, 8'd0);
        send_fields(MODE_STOP,   48'h0001_0000_0020, 11'd0, '0, '0, 8'd0);
    endtask

    // Short registers so each watchdog fires: start grace, silence, maximum duration.
    task automatic test_watchdogs();
        logic [47:0] t;
        logic [31:0] owner;
        int          k;
        t     = 48'h0002_0000_0000;
        owner = 32'h0A0B_0C0D;
        load_settings(32'd5000, 32'd300, 32'd800, 32'd200, 32'd50);
        send_fields(MODE_START, t, 11'd0, owner, '0, 8'd1);
        send_fields(MODE_TICK,  t + 100, 11'd0, '0, '0, 8'd0);
        send_fields(MODE_TICK,  t + 801, 11'd0, '0, '0, 8'd0);
        send_fields(MODE_START, t + 1000, 11'd0, owner, '0, 8'd2);
        send_fields(MODE_PACKET, t + 1100, 11'd60, owner, 32'd5, 8'd0);
        send_fields(MODE_TICK,  t + 1401, 11'd0, '0, '0, 8'd0);
        send_fields(MODE_START, t + 2000, 11'd0, owner, '0, 8'd3);
        for (k = 1; k <= 20; k++)
            send_fields(MODE_PACKET, t + 2000 + 250 * k, 11'd80, owner, 32'(k), 8'd0);
        send_fields(MODE_PACKET, t + 7001, 11'd80, owner, 32'd21, 8'd0);
    endtask

    // Mostly well-formed sessions with random content, plus noise and broken packets.
    task automatic random_beat(input int unsigned step_max);
        item_t       it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) == 0)
            clock_us = clock_us + (48'($urandom) << $urandom_range(0, 16));
        else
            clock_us = clock_us + $urandom_range(0, step_max);
        it.mode            = MODE_TICK;
        it.now_us          = clock_us;
        it.packet_length   = 11'($urandom_range(5, PKT_MAX));
        it.sender_address  = gate.owner_address;
        it.sequence_number = gate.last_phone_seq + 32'd1;
        it.connection_id   = gate.owner_connection;
        if (pick < 10) begin
            it.mode            = 3'($urandom_range(0, 7));
            it.packet_length   = 11'($urandom);
            it.sender_address  = $urandom;
            it.sequence_number = $urandom;
            it.connection_id   = 8'($urandom);
            if ($urandom_range(0, 3) == 0)
                it.now_us = clock_us - $urandom_range(1, 5000);
        end else if (!gate.session_on) begin
            it.mode           = MODE_START;
            it.sender_address = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
            it.connection_id  = 8'($urandom);
        end else if (pick < 75) begin
            it.mode = MODE_PACKET;
            case ($urandom_range(0, 9))
                0: it.sequence_number = gate.last_phone_seq + $urandom_range(2, 400);
                1: it.sequence_number = gate.last_phone_seq - $urandom_range(0, 3);
                2: it.sender_address  = $urandom;
                3: it.packet_length   = 11'($urandom);
                4: it.sequence_number = $urandom;
                default: ;
            endcase
        end else if (pick < 93) begin
            it.mode = MODE_TICK;
        end else if (pick < 96) begin
            it.mode = MODE_STOP;
        end else begin
            it.mode = MODE_CLOSE;
            if ($urandom_range(0, 1) == 0)
                it.connection_id = 8'($urandom);
        end
        send_beat(it);
    endtask

    function automatic logic [31:0] pick_period(input int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return REG_TOP;
        if (roll == 2)
            return 32'd1;
        return $urandom_range(1, hi);
    endfunction

    task automatic test_random_sessions();
        int          p;
        int          goal;
        int unsigned step_max;
        clock_us = 48'h0003_0000_0000;
        for (p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                load_settings(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
                step_max = 3;
            end else if (p == 1) begin
                load_settings(REG_TOP, REG_TOP, REG_TOP, REG_TOP, REG_TOP);
                step_max = 100000;
            end else begin
                load_settings(pick_period(60000), pick_period(4000), pick_period(4000),
                              pick_period(4000), pick_period(2000));
                step_max = $urandom_range(200, 3000);
            end
            no_idle = (p == 4) ? 1 : 0;
            goal    = active_beats + ITEM_GOAL / PHASES;
            while (active_beats < goal) begin
                random_beat(step_max);
                // hold off once mid-phase until the block has answered everything
                if (p == 3 && active_beats == goal - ITEM_GOAL / (2 * PHASES))
                    drain_results();
            end
            no_idle = 0;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        gate       = '0;
        clock_us   = '0;
        regs.max_duration_us   = MAX_DURATION_RST;
        regs.silence_limit_us  = SILENCE_RST;
        regs.start_grace_us    = GRACE_RST;
        regs.refresh_period_us = REFRESH_RST;
        regs.primer_period_us  = PRIMER_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_defaults();
        test_watchdogs();
        test_random_sessions();

        drain_results();
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end
        $display("checked %0d result beats over %0d register writes; %0d sessions,",
                 beats_checked, cfg_writes, sessions);
        $display("%0d relayed, %0d primers, %0d watchdog stops, %0d mismatches",
                 relays, primers, forced_ends, errors);
        if (errors == 0)
            $display("announce_relay_gate_tb: done, clean");
        else
            $display("announce_relay_gate_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/arg_pkg.sv
src/arg_step.sv
src/announce_relay_gate.sv
sim/announce_relay_gate_tb.sv
